>>> hdl/rcwc_pkg.sv
package rcwc_pkg;

	// screen and texture geometry
	localparam int SCREEN_HEIGHT = 512;
	localparam int TEX_SIZE      = 64;
	localparam int TEX_W         = $clog2(TEX_SIZE);

	// field widths
	localparam int COL_W   = 10;
	localparam int ROW_W   = 10;
	localparam int Y_W     = 9;
	localparam int DIST_W  = 24;
	localparam int DIR_W   = 21;
	localparam int PLAY_W  = 24;
	localparam int PITCH_W = 10;
	localparam int SIDE_W  = 2;
	localparam int KIND_W  = 4;
	localparam int MODE_W  = 2;
	localparam int SEL_W   = 3;
	localparam int RGB_W   = 24;
	localparam int FRAC_W  = 16;
	localparam int STEP_W  = 24;
	localparam int TPOS_W  = 32;

	// divider: both numerators are constants
	localparam longint H_NUM    = longint'(SCREEN_HEIGHT) << FRAC_W;
	localparam longint STEP_NUM = longint'(TEX_SIZE) << FRAC_W;
	localparam int     DIV_W    = $clog2(H_NUM) + 1;
	localparam int     CNT_W    = $clog2(DIV_W + 1);
	localparam int     SPAN_W   = DIV_W + 2;

	// operation codes
	localparam logic OP_START = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	// texture modes
	localparam logic [MODE_W-1:0] MODE_FLAT = 2'd0;
	localparam logic [MODE_W-1:0] MODE_KIND = 2'd2;

	// cell kinds with their own texture
	localparam logic [KIND_W-1:0] KIND_WALL_A = 4'd2;
	localparam logic [KIND_W-1:0] KIND_WALL_B = 4'd3;
	localparam logic [KIND_W-1:0] KIND_DOOR   = 4'd4;
	localparam logic [SEL_W-1:0]  TEX_WALL_A  = 3'd4;
	localparam logic [SEL_W-1:0]  TEX_WALL_B  = 3'd5;
	localparam logic [SEL_W-1:0]  TEX_DOOR    = 3'd6;

	localparam logic [RGB_W-1:0] FACE_RGB [4] = '{
		24'h23aa23, 24'ha2aa77, 24'h882288, 24'h1277aa
	};

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_DIV_H = 5'b00010,
		ST_SPAN  = 5'b00100,
		ST_DIV_S = 5'b01000,
		ST_POS   = 5'b10000
	} state_t;

	typedef struct packed {
		logic load;
		logic take_h;
		logic span;
		logic take_step;
		logic pos;
		logic tick;
	} ctrl_cmd_t;

	typedef struct packed {
		logic div_done;
		logic out_full;
	} ctrl_sts_t;

endpackage

>>> hdl/rcwc_if.sv
interface rcwc_col_if;
	logic                                 valid;
	logic                                 ready;
	logic                                 operation;
	logic [rcwc_pkg::COL_W-1:0]           column;
	logic [rcwc_pkg::DIST_W-1:0]          perp_dist;
	logic signed [rcwc_pkg::DIR_W-1:0]    ray_dir_x;
	logic signed [rcwc_pkg::DIR_W-1:0]    ray_dir_y;
	logic [rcwc_pkg::PLAY_W-1:0]          player_x;
	logic [rcwc_pkg::PLAY_W-1:0]          player_y;
	logic signed [rcwc_pkg::PITCH_W-1:0]  pitch;
	logic [rcwc_pkg::SIDE_W-1:0]          side;
	logic [rcwc_pkg::KIND_W-1:0]          cell_kind;

	modport source (output valid, operation, column, perp_dist, ray_dir_x, ray_dir_y,
		player_x, player_y, pitch, side, cell_kind, input ready);
	modport sink (input valid, operation, column, perp_dist, ray_dir_x, ray_dir_y,
		player_x, player_y, pitch, side, cell_kind, output ready);
endinterface

interface rcwc_pix_if;
	logic                        valid;
	logic                        ready;
	logic [rcwc_pkg::COL_W-1:0]  pixel_x;
	logic [rcwc_pkg::Y_W-1:0]    pixel_y;
	logic                        use_texture;
	logic [rcwc_pkg::RGB_W-1:0]  flat_color;
	logic [rcwc_pkg::SEL_W-1:0]  texture_select;
	logic [rcwc_pkg::TEX_W-1:0]  texel_x;
	logic [rcwc_pkg::TEX_W-1:0]  texel_y;
	logic                        darken;
	logic                        last_pixel;

	modport source (output valid, pixel_x, pixel_y, use_texture, flat_color,
		texture_select, texel_x, texel_y, darken, last_pixel, input ready);
	modport sink (input valid, pixel_x, pixel_y, use_texture, flat_color,
		texture_select, texel_x, texel_y, darken, last_pixel, output ready);
endinterface

>>> hdl/rcwc_div.sv
module rcwc_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [rcwc_pkg::DIV_W-1:0] num,
	input  logic [rcwc_pkg::DIV_W-1:0] den,
	output logic [rcwc_pkg::DIV_W-1:0] quo,
	output logic                       done
);

	logic                       busy_q;
	logic                       done_q;
	logic [rcwc_pkg::CNT_W-1:0] cnt_q;
	logic [rcwc_pkg::DIV_W-1:0] rem_q;
	logic [rcwc_pkg::DIV_W-1:0] quo_q;
	logic [rcwc_pkg::DIV_W-1:0] den_q;
	logic [rcwc_pkg::DIV_W:0]   trial;
	logic [rcwc_pkg::DIV_W:0]   diff;
	logic                       ge;

	// one restoring step per cycle, quotient bits shift in at the bottom
	always_comb begin
		trial = {rem_q, quo_q[rcwc_pkg::DIV_W-1]};
		diff  = trial - {1'b0, den_q};
		ge    = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= rcwc_pkg::CNT_W'(rcwc_pkg::DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == rcwc_pkg::CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[rcwc_pkg::DIV_W-1:0] : trial[rcwc_pkg::DIV_W-1:0];
			quo_q <= {quo_q[rcwc_pkg::DIV_W-2:0], ge};
		end
	end

	assign quo  = quo_q;
	assign done = done_q;

endmodule

>>> hdl/rcwc_ctrl.sv
module rcwc_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_operation,
	output logic                 in_ready,
	input  rcwc_pkg::ctrl_sts_t  sts,
	output rcwc_pkg::ctrl_cmd_t  cmd
);

	rcwc_pkg::state_t state_q;
	rcwc_pkg::state_t state_d;
	logic             accept;

	always_comb begin
		in_ready = (state_q == rcwc_pkg::ST_IDLE) && !sts.out_full;
		accept   = in_valid && in_ready;

		cmd           = '0;
		cmd.load      = accept && (in_operation == rcwc_pkg::OP_START);
		cmd.tick      = accept && (in_operation == rcwc_pkg::OP_TICK);
		cmd.take_h    = (state_q == rcwc_pkg::ST_DIV_H) && sts.div_done;
		cmd.span      = (state_q == rcwc_pkg::ST_SPAN);
		cmd.take_step = (state_q == rcwc_pkg::ST_DIV_S) && sts.div_done;
		cmd.pos       = (state_q == rcwc_pkg::ST_POS);

		state_d = state_q;
		case (state_q)
			rcwc_pkg::ST_IDLE:  if (cmd.load) state_d = rcwc_pkg::ST_DIV_H;
			rcwc_pkg::ST_DIV_H: if (sts.div_done) state_d = rcwc_pkg::ST_SPAN;
			rcwc_pkg::ST_SPAN:  state_d = rcwc_pkg::ST_DIV_S;
			rcwc_pkg::ST_DIV_S: if (sts.div_done) state_d = rcwc_pkg::ST_POS;
			rcwc_pkg::ST_POS:   state_d = rcwc_pkg::ST_IDLE;
			default:            state_d = rcwc_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rcwc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> hdl/rcwc_dp.sv
module rcwc_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  rcwc_pkg::ctrl_cmd_t               cmd,
	output rcwc_pkg::ctrl_sts_t               sts,
	input  logic                              cfg_we,
	input  logic [rcwc_pkg::MODE_W-1:0]       cfg_wdata,
	rcwc_col_if.sink                          col_in,
	rcwc_pix_if.source                        pix_out
);

	// configuration and column state
	logic [rcwc_pkg::MODE_W-1:0]  mode_q;
	logic                         active_q;
	logic [rcwc_pkg::COL_W-1:0]   cur_column_q;
	logic [rcwc_pkg::ROW_W-1:0]   cur_row_q;
	logic [rcwc_pkg::ROW_W-1:0]   end_row_q;
	logic [rcwc_pkg::TEX_W-1:0]   tex_column_q;
	logic [rcwc_pkg::TPOS_W-1:0]  tex_position_q;
	logic [rcwc_pkg::STEP_W-1:0]  tex_step_q;
	logic [rcwc_pkg::SIDE_W-1:0]  hit_side_q;
	logic [rcwc_pkg::SEL_W-1:0]   tex_choice_q;

	// set-up operands and intermediates
	logic [rcwc_pkg::DIST_W-1:0]         dist_q;
	logic signed [rcwc_pkg::DIR_W-1:0]   dx_q;
	logic signed [rcwc_pkg::DIR_W-1:0]   dy_q;
	logic [rcwc_pkg::PLAY_W-1:0]         px_q;
	logic [rcwc_pkg::PLAY_W-1:0]         py_q;
	logic signed [rcwc_pkg::PITCH_W-1:0] pitch_q;
	logic [rcwc_pkg::DIV_W-1:0]          h_q;
	logic signed [rcwc_pkg::SPAN_W-1:0]  term_q;
	logic [rcwc_pkg::ROW_W-1:0]          start_q;
	logic [rcwc_pkg::ROW_W-1:0]          end_q;
	logic                                span_ok_q;

	// output register
	logic                         out_valid_q;
	logic [rcwc_pkg::COL_W-1:0]   out_x_q;
	logic [rcwc_pkg::Y_W-1:0]     out_y_q;
	logic                         out_tex_q;
	logic [rcwc_pkg::RGB_W-1:0]   out_rgb_q;
	logic [rcwc_pkg::SEL_W-1:0]   out_sel_q;
	logic [rcwc_pkg::TEX_W-1:0]   out_tx_q;
	logic [rcwc_pkg::TEX_W-1:0]   out_ty_q;
	logic                         out_dark_q;
	logic                         out_last_q;

	// divider
	logic                         div_start;
	logic [rcwc_pkg::DIV_W-1:0]   div_num;
	logic [rcwc_pkg::DIV_W-1:0]   div_den;
	logic [rcwc_pkg::DIV_W-1:0]   div_quo;
	logic                         div_done;
	logic [rcwc_pkg::DIST_W-1:0]  dist_fix;

	// span logic
	logic signed [rcwc_pkg::SPAN_W-1:0]  half_lo;
	logic signed [rcwc_pkg::SPAN_W-1:0]  half_hi;
	logic signed [rcwc_pkg::SPAN_W-1:0]  base_row;
	logic signed [rcwc_pkg::SPAN_W-1:0]  start_raw;
	logic signed [rcwc_pkg::SPAN_W-1:0]  end_raw;
	logic signed [rcwc_pkg::SPAN_W-1:0]  start_c;
	logic signed [rcwc_pkg::SPAN_W-1:0]  end_c;
	logic signed [rcwc_pkg::SPAN_W-1:0]  term_c;

	// wall hit column
	logic signed [rcwc_pkg::DIR_W-1:0]                  dir_sel;
	logic signed [rcwc_pkg::DIR_W-1:0]                  dir_mir;
	logic [rcwc_pkg::PLAY_W-1:0]                        play_sel;
	logic signed [rcwc_pkg::DIST_W+rcwc_pkg::DIR_W:0]   wall_prod;
	logic [rcwc_pkg::TPOS_W-1:0]                        wall_frac;
	logic [rcwc_pkg::TEX_W-1:0]                         tx_raw;
	logic                                               mirror;

	// texel start position and step
	logic signed [rcwc_pkg::SPAN_W+rcwc_pkg::STEP_W:0]  pos_prod;
	logic [rcwc_pkg::STEP_W-1:0]                        step_sat;

	// pixel tick
	logic                         emit;
	logic                         last;
	logic [rcwc_pkg::ROW_W:0]     row_inc;
	logic [rcwc_pkg::TPOS_W:0]    rnd_pos;
	logic [rcwc_pkg::TPOS_W:0]    rnd_mag;
	logic [rcwc_pkg::TPOS_W:0]    rnd_neg;
	logic [rcwc_pkg::TEX_W-1:0]   ty;

	assign dist_fix  = (col_in.perp_dist == '0) ? rcwc_pkg::DIST_W'(1) : col_in.perp_dist;
	assign div_start = cmd.load || cmd.span;
	assign div_num   = cmd.load ? rcwc_pkg::DIV_W'(rcwc_pkg::H_NUM)
		: rcwc_pkg::DIV_W'(rcwc_pkg::STEP_NUM);
	assign div_den   = cmd.load ? rcwc_pkg::DIV_W'(dist_fix) : h_q;

	rcwc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.quo    (div_quo),
		.done   (div_done)
	);

	always_comb begin
		half_lo   = rcwc_pkg::SPAN_W'(h_q >> 1);
		half_hi   = rcwc_pkg::SPAN_W'(({1'b0, h_q} + (rcwc_pkg::DIV_W+1)'(1)) >> 1);
		base_row  = rcwc_pkg::SPAN_W'(rcwc_pkg::SCREEN_HEIGHT / 2)
			+ rcwc_pkg::SPAN_W'(pitch_q);
		start_raw = base_row - half_hi;
		end_raw   = base_row + half_lo;
		start_c   = (start_raw < 0) ? '0 : start_raw;
		end_c     = (end_raw >= rcwc_pkg::SPAN_W'(rcwc_pkg::SCREEN_HEIGHT))
			? rcwc_pkg::SPAN_W'(rcwc_pkg::SCREEN_HEIGHT - 1) : end_raw;
		term_c    = start_c - base_row + half_lo;

		// x faces sample the y coordinate of the hit and the other way round
		dir_sel   = (hit_side_q <= 2'd1) ? dy_q : dx_q;
		dir_mir   = (hit_side_q <= 2'd1) ? dx_q : dy_q;
		play_sel  = (hit_side_q <= 2'd1) ? py_q : px_q;
		wall_prod = $signed({1'b0, dist_q}) * dir_sel;
		wall_frac = {play_sel[rcwc_pkg::FRAC_W-1:0], rcwc_pkg::FRAC_W'(0)}
			+ wall_prod[rcwc_pkg::TPOS_W-1:0];
		tx_raw    = wall_frac[rcwc_pkg::TPOS_W-1 -: rcwc_pkg::TEX_W];
		mirror    = !dir_mir[rcwc_pkg::DIR_W-1] && (dir_mir != '0);

		pos_prod  = term_q * $signed({1'b0, tex_step_q});
		step_sat  = (div_quo > rcwc_pkg::DIV_W'({rcwc_pkg::STEP_W{1'b1}}))
			? '1 : div_quo[rcwc_pkg::STEP_W-1:0];
	end

	always_comb begin
		emit    = cmd.tick && active_q;
		row_inc = {1'b0, cur_row_q} + (rcwc_pkg::ROW_W+1)'(1);
		last    = row_inc >= {1'b0, end_row_q};

		// round half away from zero, then wrap to the texture height
		rnd_pos = {1'b0, tex_position_q} + (rcwc_pkg::TPOS_W+1)'(1 << (rcwc_pkg::FRAC_W - 1));
		rnd_mag = (rcwc_pkg::TPOS_W+1)'(0)
			- {tex_position_q[rcwc_pkg::TPOS_W-1], tex_position_q}
			+ (rcwc_pkg::TPOS_W+1)'(1 << (rcwc_pkg::FRAC_W - 1));
		rnd_neg = (rcwc_pkg::TPOS_W+1)'(0) - (rnd_mag >> rcwc_pkg::FRAC_W);
		ty      = tex_position_q[rcwc_pkg::TPOS_W-1]
			? rnd_neg[rcwc_pkg::TEX_W-1:0]
			: rnd_pos[rcwc_pkg::FRAC_W +: rcwc_pkg::TEX_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= rcwc_pkg::MODE_FLAT;
			active_q       <= 1'b0;
			cur_column_q   <= '0;
			cur_row_q      <= '0;
			end_row_q      <= '0;
			tex_column_q   <= '0;
			tex_position_q <= '0;
			tex_step_q     <= '0;
			hit_side_q     <= '0;
			tex_choice_q   <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				mode_q <= cfg_wdata;
			end
			if (cmd.load) begin
				active_q     <= 1'b0;
				cur_column_q <= col_in.column;
				hit_side_q   <= col_in.side;
				case (col_in.cell_kind)
					rcwc_pkg::KIND_WALL_A: tex_choice_q <= rcwc_pkg::TEX_WALL_A;
					rcwc_pkg::KIND_WALL_B: tex_choice_q <= rcwc_pkg::TEX_WALL_B;
					rcwc_pkg::KIND_DOOR:   tex_choice_q <= rcwc_pkg::TEX_DOOR;
					default:               tex_choice_q <= rcwc_pkg::SEL_W'(col_in.side);
				endcase
			end
			if (cmd.span) begin
				tex_column_q <= mirror ? ~tx_raw : tx_raw;
			end
			if (cmd.take_step) begin
				tex_step_q <= step_sat;
			end
			if (cmd.pos) begin
				tex_position_q <= pos_prod[rcwc_pkg::TPOS_W-1:0];
				if (span_ok_q) begin
					active_q  <= 1'b1;
					cur_row_q <= start_q;
					end_row_q <= end_q;
				end
			end
			if (emit) begin
				cur_row_q <= row_inc[rcwc_pkg::ROW_W-1:0];
				if (last) begin
					active_q <= 1'b0;
				end
				// flat pixels leave the texel position where it is
				if (mode_q != rcwc_pkg::MODE_FLAT) begin
					tex_position_q <= tex_position_q + rcwc_pkg::TPOS_W'(tex_step_q);
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (pix_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dist_q  <= dist_fix;
			dx_q    <= col_in.ray_dir_x;
			dy_q    <= col_in.ray_dir_y;
			px_q    <= col_in.player_x;
			py_q    <= col_in.player_y;
			pitch_q <= col_in.pitch;
		end
		if (cmd.take_h) begin
			h_q <= div_quo;
		end
		if (cmd.span) begin
			term_q    <= term_c;
			start_q   <= start_c[rcwc_pkg::ROW_W-1:0];
			end_q     <= end_c[rcwc_pkg::ROW_W-1:0];
			span_ok_q <= (h_q != '0) && (start_c < end_c);
		end
		if (emit) begin
			out_x_q    <= cur_column_q;
			out_y_q    <= cur_row_q[rcwc_pkg::Y_W-1:0];
			out_last_q <= last;
			if (mode_q == rcwc_pkg::MODE_FLAT) begin
				out_tex_q  <= 1'b0;
				out_rgb_q  <= rcwc_pkg::FACE_RGB[hit_side_q];
				out_sel_q  <= '0;
				out_tx_q   <= '0;
				out_ty_q   <= '0;
				out_dark_q <= 1'b0;
			end else begin
				out_tex_q  <= 1'b1;
				out_rgb_q  <= '0;
				out_sel_q  <= (mode_q == rcwc_pkg::MODE_KIND) ? tex_choice_q
					: rcwc_pkg::SEL_W'(hit_side_q);
				out_tx_q   <= tex_column_q;
				out_ty_q   <= ty;
				out_dark_q <= (hit_side_q == 2'd1) || (hit_side_q == 2'd2);
			end
		end
	end

	assign sts.div_done = div_done;
	assign sts.out_full = out_valid_q && !pix_out.ready;

	assign pix_out.valid          = out_valid_q;
	assign pix_out.pixel_x        = out_x_q;
	assign pix_out.pixel_y        = out_y_q;
	assign pix_out.use_texture    = out_tex_q;
	assign pix_out.flat_color     = out_rgb_q;
	assign pix_out.texture_select = out_sel_q;
	assign pix_out.texel_x        = out_tx_q;
	assign pix_out.texel_y        = out_ty_q;
	assign pix_out.darken         = out_dark_q;
	assign pix_out.last_pixel     = out_last_q;

`ifndef NO_ASSERTIONS
	a_last_ends_column: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_last_q) |-> !active_q)
		else $error("column still active after its last pixel");

	a_row_below_end: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (cur_row_q < end_row_q))
		else $error("active column has no row left");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.tick && out_valid_q) |-> pix_out.ready)
		else $error("tick taken while a stalled pixel waits");
`endif

endmodule

>>> hdl/raycast_wall_column_texel_gen_core.sv
// Textured wall column generator for a grid raycaster. A start transfer
// (operation 0) carries one ray hit; in set-up one shared restoring divider,
// one quotient bit per cycle over 26 bits, first gives the line height from
// the wall distance, then the texel step from the line height, with the span
// clamp and texel column between and the texel start position after. col_in
// is not ready during set-up. After that every tick transfer (operation 1)
// yields one pixel of the column, one per cycle while pix_out is taken,
// with a registered output so a new tick is taken in the same cycle the
// previous pixel leaves. A tick with no column open, or a column whose span
// is empty, gives no pixel. The user must write texture_mode through
// cfg_we/cfg_wdata only while the block is idle; the block does not enforce it.
module raycast_wall_column_texel_gen_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [rcwc_pkg::MODE_W-1:0]  cfg_wdata,
	rcwc_col_if.sink                     col_in,
	rcwc_pix_if.source                   pix_out
);

	// command and status between sequencer and datapath
	rcwc_pkg::ctrl_cmd_t cmd;
	rcwc_pkg::ctrl_sts_t sts;
	logic                in_ready;

	// sequencer: gates transfers and steps the set-up through the divider
	rcwc_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (col_in.valid),
		.in_operation (col_in.operation),
		.in_ready     (in_ready),
		.sts          (sts),
		.cmd          (cmd)
	);

	// datapath: column state, divider, span math and pixel output register
	rcwc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.col_in    (col_in),
		.pix_out   (pix_out)
	);

	assign col_in.ready = in_ready;

endmodule
